// ===== design/swcg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register indexes and types of the sky wall column generator.
// No dependencies; swcg_div and the top level refer to it by scoped names.
package swcg_pkg;

   // screen geometry (rows)
   localparam int SCREEN_HEIGHT    = 240;
   localparam int HALF_VIEW_HEIGHT = 100;

   // width that holds any allowed SCREEN_HEIGHT (up to 2047)
   localparam int ROWS_W = 11;

   // configuration register indexes
   localparam logic [1:0] CSR_VIEW_HEIGHT    = 2'd0;
   localparam logic [1:0] CSR_SKY_U_OFFSET   = 2'd1;
   localparam logic [1:0] CSR_TEX_WIDTH_MASK = 2'd2;
   localparam logic [1:0] CSR_TEX_HEIGHT     = 2'd3;

   // input command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // divider width: dividend is a 32 bit magnitude, divisor the edge width
   localparam int DIV_N = 32;
   localparam int DIV_D = 16;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== design/swcg_mul.sv =====
`timescale 1ns / 1ps
// Shared 32x32 multiplier, low 32 bits of the product, registered output.
// Depends on nothing but the operands selected by the sequencer.
module swcg_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [31:0] product_ff
);

   logic [31:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== design/swcg_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Uses swcg_pkg for widths and the status struct.
module swcg_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [swcg_pkg::DIV_N-1:0]  dividend,
   input  logic [swcg_pkg::DIV_D-1:0]  divisor,
   output logic [swcg_pkg::DIV_N-1:0]  quotient,
   output swcg_pkg::div_status_type    status
);

   localparam int CNT_W = $clog2(swcg_pkg::DIV_N);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [swcg_pkg::DIV_N-1:0]  quo_ff, quo_in;
   logic [swcg_pkg::DIV_D-1:0]  rem_ff, rem_in;
   logic [swcg_pkg::DIV_D-1:0]  dsr_ff, dsr_in;
   logic [swcg_pkg::DIV_D:0]    trial;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[swcg_pkg::DIV_N-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[swcg_pkg::DIV_N-2:0], fits};
         rem_in   = fits ? swcg_pkg::DIV_D'(trial - {1'b0, dsr_ff})
                         : trial[swcg_pkg::DIV_D-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(swcg_pkg::DIV_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign status   = {busy_ff, done_ff};

endmodule

// ===== design/sky_wall_column_generator.sv =====
`timescale 1ns / 1ps
// Sky wall column generator top level: edge set-up sequencer and column stepper.
// Depends on swcg_pkg, swcg_mul and swcg_div.
//
// Usage:
//  - req_* carries commands. tuser[0] is the command: load an edge or step one
//    column. A load fills the edge state; a step returns exactly one rsp transfer.
//  - A load is one transfer; req_tready then stays low during set-up: two products
//    on the shared 32x32 multiplier, a divider start, the restoring divide and a
//    finish for the y step, then one more product plus add to skip hidden columns.
//    An empty edge (stop x not above start x) finishes in the accept cycle.
//  - For steps, req_tready stays high and steps stream one per clock while rsp
//    is taken. The result sits in an output register, so the next step is accepted
//    in the same cycle the previous result is taken.
//  - When rsp_tready is low with a result pending, req_tready drops until the
//    result leaves; nothing is dropped or repeated.
//  - csr_* writes configuration in the same cycle. The user writes only while no
//    load is running; the block itself does not enforce it.
//  - reset (synchronous, active high) clears the edge state to an empty edge and
//    restores register defaults (width mask 255, texture height 128).
module sky_wall_column_generator (
   input  logic         clock,
   input  logic         reset,
   // input command channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: edge_x_start[15:0], edge_x_stop[31:16], scale_start[63:32],
   //        scale_stop[95:64], wall_height[127:96], visible_first[143:128],
   //        visible_limit[159:144]
   input  logic [159:0] req_tdata,
   // tuser: command[0], upper_wall[1]
   input  logic [1:0]   req_tuser,
   // column result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: column_x[15:0], column_y[31:16], column_rows[47:32],
   //        tex_u[55:48], tex_v[63:56]
   output logic [63:0]  rsp_tdata,
   // tuser: column_drawn[0]
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tlast,
   // configuration write port
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P1,
      ST_MUL_P2,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SKIP_MUL,
      ST_SKIP_ADD
   } state_type;

   localparam logic [31:0] Y_CENTER = 32'(swcg_pkg::HALF_VIEW_HEIGHT) << 16;
   localparam logic [swcg_pkg::ROWS_W-1:0] CLIP_MAX =
      swcg_pkg::ROWS_W'(swcg_pkg::SCREEN_HEIGHT);

   // configuration
   logic [31:0] view_height_ff, view_height_in;
   logic [7:0]  sky_u_offset_ff, sky_u_offset_in;
   logic [7:0]  tex_width_mask_ff, tex_width_mask_in;
   logic [8:0]  tex_height_ff, tex_height_in;

   // edge state
   state_type   state_ff, state_in;
   logic [15:0] cur_ff, cur_in;
   logic [15:0] end_ff, end_in;
   logic [31:0] y_accum_ff, y_accum_in;
   logic [31:0] y_inc_ff, y_inc_in;
   logic        upper_ff, upper_in;

   // set-up operands (payload)
   logic [31:0] iz_ff, iz_in;
   logic [31:0] s1_ff, s1_in;
   logic [31:0] s2_ff, s2_in;
   logic [31:0] p1_ff, p1_in;
   logic [15:0] dx_ff, dx_in;
   logic [16:0] skip_ff, skip_in;
   logic        skip_en_ff, skip_en_in;
   logic        neg_ff, neg_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic        rsp_drawn_ff, rsp_drawn_in;
   logic        rsp_last_ff, rsp_last_in;

   // shared units
   logic [31:0] mul_a, mul_b, product;
   logic        div_start;
   logic [31:0] div_dividend, quotient;
   swcg_pkg::div_status_type div_status;

   // request fields
   logic [15:0] x1, x2, vf, vl;
   logic [31:0] s1, s2, z;
   logic        req_take, is_step;

   // load decode
   logic [16:0] dx17;
   logic        dx_pos;
   logic [31:0] z_diff;
   logic        vf_gt;
   logic [15:0] cur_start, end_tmp, end_fix;

   // column step
   logic        edge_done;
   logic [15:0] y;
   logic [16:0] y_p1;
   logic [15:0] rows_up;
   logic [swcg_pkg::ROWS_W-1:0] th_ext, end_y;
   logic [16:0] end_y17;
   logic        drawn_up, drawn_lo, drawn;
   logic [15:0] rows, ycol;
   logic [7:0]  u, v;
   logic        last;
   logic [31:0] dy, dy_mag;

   assign x1 = req_tdata[15:0];
   assign x2 = req_tdata[31:16];
   assign s1 = req_tdata[63:32];
   assign s2 = req_tdata[95:64];
   assign z  = req_tdata[127:96];
   assign vf = req_tdata[143:128];
   assign vl = req_tdata[159:144];

   // accept only when idle and the result slot is free or draining
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_take   = req_tvalid && req_tready;
   assign is_step    = req_tuser[0] == swcg_pkg::CMD_STEP;

   // edge decode
   assign dx17    = {x2[15], x2} - {x1[15], x1};
   assign dx_pos  = !dx17[16] && (dx17 != 17'd0);
   assign z_diff  = z - view_height_ff;
   assign vf_gt   = $signed(vf) > $signed(x1);
   assign cur_start = vf_gt ? vf : x1;
   assign end_tmp = ($signed(x2) < $signed(vl)) ? x2 : vl;
   assign end_fix = ($signed(cur_start) > $signed(end_tmp)) ? cur_start : end_tmp;

   // column evaluation from the current edge state
   assign edge_done = $signed(cur_ff) >= $signed(end_ff);
   assign y         = y_accum_ff[31:16];

   // upper wall: screen top down to y, clipped to texture height
   assign drawn_up = !y[15];
   assign y_p1     = {1'b0, y} + 17'd1;
   assign rows_up  = (y_p1 < {8'd0, tex_height_ff}) ? y_p1[15:0] : {7'd0, tex_height_ff};

   // lower wall: y down to min(texture height, screen height)
   assign th_ext   = swcg_pkg::ROWS_W'(tex_height_ff);
   assign end_y    = (th_ext < CLIP_MAX) ? th_ext : CLIP_MAX;
   assign end_y17  = 17'(end_y);
   assign drawn_lo = $signed({y[15], y}) < $signed(end_y17);

   assign drawn = upper_ff ? drawn_up : drawn_lo;

   always_comb begin
      rows = '0;
      ycol = '0;
      v    = '0;
      if (drawn) begin
         if (upper_ff) begin
            rows = rows_up;
         end else begin
            rows = 16'(end_y17 - {y[15], y});
            ycol = y;
            v    = y[7:0];
         end
      end
   end

   assign u    = drawn ? ((cur_ff[7:0] + sky_u_offset_ff) & tex_width_mask_ff) : 8'd0;
   assign last = $signed({cur_ff[15], cur_ff} + 17'd1) >= $signed({end_ff[15], end_ff});

   // y step numerator: p2 - p1, split into sign and magnitude for the divider
   assign dy           = product - p1_ff;
   assign dy_mag       = dy[31] ? (32'd0 - dy) : dy;
   assign div_start    = state_ff == ST_DIV_START;
   assign div_dividend = dy_mag;

   // multiplier operand select
   always_comb begin
      mul_a = iz_ff;
      mul_b = s1_ff;
      case (state_ff)
         ST_MUL_P2:   mul_b = s2_ff;
         ST_SKIP_MUL: begin
            mul_a = 32'(skip_ff);
            mul_b = y_inc_ff;
         end
         default:     mul_b = s1_ff;
      endcase
   end

   always_comb begin
      view_height_in    = view_height_ff;
      sky_u_offset_in   = sky_u_offset_ff;
      tex_width_mask_in = tex_width_mask_ff;
      tex_height_in     = tex_height_ff;
      state_in          = state_ff;
      cur_in            = cur_ff;
      end_in            = end_ff;
      y_accum_in        = y_accum_ff;
      y_inc_in          = y_inc_ff;
      upper_in          = upper_ff;
      iz_in             = iz_ff;
      s1_in             = s1_ff;
      s2_in             = s2_ff;
      p1_in             = p1_ff;
      dx_in             = dx_ff;
      skip_in           = skip_ff;
      skip_en_in        = skip_en_ff;
      neg_in            = neg_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_data_in       = rsp_data_ff;
      rsp_drawn_in      = rsp_drawn_ff;
      rsp_last_in       = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            swcg_pkg::CSR_VIEW_HEIGHT:    view_height_in    = csr_wdata;
            swcg_pkg::CSR_SKY_U_OFFSET:   sky_u_offset_in   = csr_wdata[7:0];
            swcg_pkg::CSR_TEX_WIDTH_MASK: tex_width_mask_in = csr_wdata[7:0];
            swcg_pkg::CSR_TEX_HEIGHT:     tex_height_in     = csr_wdata[8:0];
            default:                      tex_height_in     = tex_height_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && is_step) begin
               rsp_valid_in = 1'b1;
               if (edge_done) begin
                  rsp_data_in  = '0;
                  rsp_drawn_in = 1'b0;
                  rsp_last_in  = 1'b1;
               end else begin
                  rsp_data_in  = {v, u, rows, ycol, cur_ff};
                  rsp_drawn_in = drawn;
                  rsp_last_in  = last;
                  cur_in       = cur_ff + 16'd1;
                  y_accum_in   = y_accum_ff + y_inc_ff;
               end
            end else if (req_take) begin
               upper_in   = req_tuser[1];
               iz_in      = 32'd0 - {{16{z_diff[31]}}, z_diff[31:16]};
               s1_in      = s1;
               s2_in      = s2;
               dx_in      = dx17[15:0];
               skip_in    = {vf[15], vf} - {x1[15], x1};
               skip_en_in = vf_gt;
               if (dx_pos) begin
                  cur_in   = cur_start;
                  end_in   = end_fix;
                  state_in = ST_MUL_P1;
               end else begin
                  // empty edge: done at once
                  cur_in     = '0;
                  end_in     = '0;
                  y_accum_in = '0;
                  y_inc_in   = '0;
               end
            end
         end
         ST_MUL_P1:    state_in = ST_MUL_P2;
         ST_MUL_P2: begin
            p1_in    = product;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            neg_in   = dy[31];
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               y_inc_in   = neg_ff ? (32'd0 - quotient) : quotient;
               y_accum_in = p1_ff + Y_CENTER;
               state_in   = skip_en_ff ? ST_SKIP_MUL : ST_IDLE;
            end
         end
         ST_SKIP_MUL:  state_in = ST_SKIP_ADD;
         ST_SKIP_ADD: begin
            // step past the hidden columns at the front of the edge
            y_accum_in = y_accum_ff + product;
            state_in   = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_height_ff    <= '0;
         sky_u_offset_ff   <= '0;
         tex_width_mask_ff <= 8'hFF;
         tex_height_ff     <= 9'd128;
         state_ff          <= ST_IDLE;
         cur_ff            <= '0;
         end_ff            <= '0;
         y_accum_ff        <= '0;
         y_inc_ff          <= '0;
         upper_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         view_height_ff    <= view_height_in;
         sky_u_offset_ff   <= sky_u_offset_in;
         tex_width_mask_ff <= tex_width_mask_in;
         tex_height_ff     <= tex_height_in;
         state_ff          <= state_in;
         cur_ff            <= cur_in;
         end_ff            <= end_in;
         y_accum_ff        <= y_accum_in;
         y_inc_ff          <= y_inc_in;
         upper_ff          <= upper_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      iz_ff        <= iz_in;
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      p1_ff        <= p1_in;
      dx_ff        <= dx_in;
      skip_ff      <= skip_in;
      skip_en_ff   <= skip_en_in;
      neg_ff       <= neg_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_drawn_ff <= rsp_drawn_in;
      rsp_last_ff  <= rsp_last_in;
   end

   swcg_mul u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (product)
   );

   swcg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dx_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_drawn_ff;
   assign rsp_tlast    = rsp_last_ff;

   // the column pointer never passes the edge end
   a_cur_le_end: assert property (@(posedge clock) disable iff (reset)
      $signed(cur_ff) <= $signed(end_ff))
      else $error("column pointer beyond edge end");

   // a column that is not drawn carries no height
   a_undrawn_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_drawn_ff |-> rsp_data_ff[47:16] == 32'd0)
      else $error("undrawn column with nonzero y or rows");

   // the divider is only waited on while it runs or has just finished
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_WAIT |-> div_status.busy || div_status.done)
      else $error("waiting on an idle divider");

   // no divide is started while one is in flight
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

endmodule

// ===== tb/tb_sky_wall_column_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sky_wall_column_generator: edge loads and column steps
// are predicted in-line and every column transfer is compared field by field.
// Depends on swcg_pkg and the sky_wall_column_generator RTL only.
module tb_sky_wall_column_generator;

   // settle time after the last expected column: covers a full edge set-up
   localparam int LOAD_CYCLES = 64;
   // run length target, directed part included
   localparam int ITEM_TARGET = 400;

   // one load item as it travels on req_tdata / req_tuser
   typedef struct {
      logic               upper;
      logic signed [15:0] x_start;
      logic signed [15:0] x_stop;
      logic signed [31:0] scale_start;
      logic signed [31:0] scale_stop;
      logic signed [31:0] wall_z;
      logic signed [15:0] vis_first;
      logic signed [15:0] vis_limit;
   } wall_seg_type;

   // one sky column as it comes back on rsp_*
   typedef struct {
      logic               drawn;
      logic               last;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] rows;
      logic [7:0]         u;
      logic [7:0]         v;
   } sky_col_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // tdata: edge_x_start, edge_x_stop, scale_start, scale_stop, wall_height,
   //        visible_first, visible_limit (lowest bits first)
   logic [159:0] req_tdata = '0;
   // tuser: command, upper_wall
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // tdata: column_x, column_y, column_rows, tex_u, tex_v
   logic [63:0]  rsp_tdata;
   // tuser: column_drawn
   logic [0:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = swcg_pkg::CSR_VIEW_HEIGHT;
   logic [31:0]  csr_wdata = '0;

   // register shadows, reset values of the block
   logic [31:0] view_h     = 32'd0;
   logic [7:0]  u_off      = 8'd0;
   logic [7:0]  width_mask = 8'd255;
   logic [8:0]  tex_h      = 9'd128;

   // edge stepper shadow state
   int          col_cur  = 0;
   int          col_end  = 0;
   logic [31:0] y_pos    = '0;   // 16.16 y of the current column
   logic [31:0] y_step   = '0;   // 16.16 y change per column
   logic        seg_upper = 1'b0;

   sky_col_type expected_cols[$];
   int       mismatches = 0;
   int       items_sent = 0;
   bit       no_idle    = 1'b0; // set for stretches with no gaps or stalls on either side
   int       rsp_gap    = 0;

   sky_wall_column_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Edge set-up: negated relative wall height, per-column y step by truncating
   // division, start y, then skip of the hidden leading columns.
   function automatic void predict_load(wall_seg_type s);
      int                 x1, x2, dx, vf, vl;
      logic signed [31:0] rel_z, z_int, dy32;
      logic [31:0]        inv_z, p1, p2;
      x1 = int'(s.x_start);
      x2 = int'(s.x_stop);
      vf = int'(s.vis_first);
      vl = int'(s.vis_limit);
      dx = x2 - x1;
      seg_upper = s.upper;
      if (dx <= 0) begin
         // zero or negative width: done at once
         col_cur = 0;
         col_end = 0;
         y_pos   = '0;
         y_step  = '0;
         return;
      end
      rel_z  = s.wall_z - view_h;
      z_int  = rel_z >>> 16;
      inv_z  = 32'd0 - z_int;
      p1     = inv_z * s.scale_start;
      p2     = inv_z * s.scale_stop;
      dy32   = p2 - p1;
      y_step = 32'(longint'(dy32) / longint'(dx));
      y_pos  = p1 + (32'(swcg_pkg::HALF_VIEW_HEIGHT) << 16);
      col_cur = x1;
      if (vf > x1) begin
         y_pos   = y_pos + 32'(vf - x1) * y_step;
         col_cur = vf;
      end
      col_end = (x2 < vl) ? x2 : vl;
      if (col_cur > col_end)
         col_end = col_cur;
   endfunction

   // One column step; advances the shadow stepper.
   function automatic sky_col_type predict_step();
      sky_col_type        c;
      logic signed [31:0] y_full;
      logic signed [15:0] y16;
      int                 y, th, clip;
      c = '{default: '0};
      if (col_cur >= col_end) begin
         // stepping a finished edge: empty column, marked last
         c.last = 1'b1;
         return c;
      end
      y_full = $signed(y_pos) >>> 16;
      y16    = y_full[15:0];
      y      = int'(y16);
      th     = int'(tex_h);
      if (seg_upper) begin
         // screen top down to the edge, clipped to the texture height
         c.drawn = (y >= 0);
         if (c.drawn)
            c.rows = 16'((y + 1 < th) ? y + 1 : th);
      end else begin
         // edge down, clipped to texture or screen height, whichever is less
         clip    = (th < swcg_pkg::SCREEN_HEIGHT) ? th : swcg_pkg::SCREEN_HEIGHT;
         c.drawn = (y < clip);
         if (c.drawn) begin
            c.y    = y16;
            c.rows = 16'(clip - y);
            c.v    = y16[7:0];
         end
      end
      if (c.drawn)
         c.u = 8'(col_cur + u_off) & width_mask;
      c.last = (col_cur + 1 >= col_end);
      c.x    = 16'(col_cur);
      col_cur = col_cur + 1;
      y_pos   = y_pos + y_step;
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // compare each accepted column transfer with the oldest expectation
   always @(posedge clock) begin : column_compare
      sky_col_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.drawn = rsp_tuser[0];
         got.last  = rsp_tlast;
         got.x     = rsp_tdata[15:0];
         got.y     = rsp_tdata[31:16];
         got.rows  = rsp_tdata[47:32];
         got.u     = rsp_tdata[55:48];
         got.v     = rsp_tdata[63:56];
         if (expected_cols.size() == 0) begin
            report_mismatch("column with none expected, x", got.x, 0);
         end else begin
            want = expected_cols.pop_front();
            if (got.drawn !== want.drawn) report_mismatch("column_drawn", got.drawn, want.drawn);
            if (got.last !== want.last)   report_mismatch("last_column", got.last, want.last);
            if (got.x !== want.x)         report_mismatch("column_x", got.x, want.x);
            if (got.y !== want.y)         report_mismatch("column_y", got.y, want.y);
            if (got.rows !== want.rows)   report_mismatch("column_rows", got.rows, want.rows);
            if (got.u !== want.u)         report_mismatch("tex_u", got.u, want.u);
            if (got.v !== want.v)         report_mismatch("tex_v", got.v, want.v);
         end
      end
   end

   // Result side: after each transfer, rsp_tready drops for a random stall, possibly none (none in no_idle stretches).
   always @(posedge clock) begin : result_backpressure
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            gap = no_idle ? 0 : $urandom_range(0, 9);
         else
            gap = rsp_gap;
         if (gap == 0) begin
            rsp_tready <= 1'b1;
            rsp_gap    <= 0;
         end else begin
            rsp_tready <= 1'b0;
            rsp_gap    <= gap - 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic wall_seg_type random_seg();
      wall_seg_type s;
      s.upper       = 1'($urandom_range(0, 1));
      s.x_start     = 16'($urandom);
      s.x_stop      = 16'($urandom);
      s.scale_start = $urandom;
      s.scale_stop  = $urandom;
      s.wall_z      = $urandom;
      s.vis_first   = 16'($urandom);
      s.vis_limit   = 16'($urandom);
      return s;
   endfunction

   function automatic wall_seg_type make_seg(logic up, int xs, int xe, logic [31:0] s1,
                                             logic [31:0] s2, logic [31:0] z, int vf,
                                             int vl);
      wall_seg_type s;
      s.upper       = up;
      s.x_start     = 16'(xs);
      s.x_stop      = 16'(xe);
      s.scale_start = s1;
      s.scale_stop  = s2;
      s.wall_z      = z;
      s.vis_first   = 16'(vf);
      s.vis_limit   = 16'(vl);
      return s;
   endfunction

   // One input transfer after a random gap; tvalid stays up when the gap is zero.
   task automatic send_item(logic cmd, wall_seg_type s);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {s.upper, cmd};
      req_tdata  <= {s.vis_limit, s.vis_first, s.wall_z, s.scale_stop, s.scale_start,
                     s.x_stop, s.x_start};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (cmd == swcg_pkg::CMD_LOAD)
         predict_load(s);
      else
         expected_cols.push_back(predict_step());
   endtask

   // Hold off until every column is back, then let a running edge set-up finish.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_cols.size() != 0) @(posedge clock);
      repeat (LOAD_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [1:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // All four registers, back to back, only with the block idle.
   task automatic write_regs(logic [31:0] vh, logic [7:0] off, logic [7:0] mask,
                             logic [8:0] th);
      drain();
      csr_put(swcg_pkg::CSR_VIEW_HEIGHT, vh);
      csr_put(swcg_pkg::CSR_SKY_U_OFFSET, 32'(off));
      csr_put(swcg_pkg::CSR_TEX_WIDTH_MASK, 32'(mask));
      csr_put(swcg_pkg::CSR_TEX_HEIGHT, 32'(th));
      csr_we     <= 1'b0;
      view_h     = vh;
      u_off      = off;
      width_mask = mask;
      tex_h      = th;
   endtask

   // A plausible edge with random content: small width, y mostly near the screen,
   // then enough steps to walk it out and hit the finished state.
   // cut_short stops part-way so the next load interrupts the edge.
   task automatic run_wall_edge(bit cut_short);
      wall_seg_type s;
      int        n;
      s = random_seg();
      s.x_start   = 16'(int'($urandom_range(0, 360)) - 40);
      s.x_stop    = 16'(int'(s.x_start) + int'($urandom_range(0, 26)) - 2);
      s.vis_first = 16'(int'(s.x_start) + int'($urandom_range(0, 8)) - 3);
      s.vis_limit = 16'(int'(s.x_stop) + int'($urandom_range(0, 6)) - 4);
      s.wall_z    = view_h + ((int'($urandom_range(0, 400)) - 200) <<< 16)
                    + $urandom_range(0, 65535);
      s.scale_start = $urandom_range(0, 5 * 32768);
      s.scale_stop  = $urandom_range(0, 5 * 32768);
      if ($urandom_range(0, 7) == 0) s.scale_start = -s.scale_start;
      if ($urandom_range(0, 7) == 0) s.scale_stop = -s.scale_stop;
      send_item(swcg_pkg::CMD_LOAD, s);
      n = col_end - col_cur + $urandom_range(0, 2);
      if (cut_short)
         n = $urandom_range(0, n);
      if (n > 40)
         n = 40;
      repeat (n) send_item(swcg_pkg::CMD_STEP, random_seg());
   endtask

   // Unstructured traffic: fully random loads and stray steps.
   task automatic run_noise();
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 1))
            send_item(swcg_pkg::CMD_LOAD, random_seg());
         else
            send_item(swcg_pkg::CMD_STEP, random_seg());
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Directed edges under the reset register values.
   task automatic test_directed_edges();
      // step straight after reset: empty edge
      send_item(swcg_pkg::CMD_STEP, random_seg());
      // zero width, then reversed extreme width
      send_item(swcg_pkg::CMD_LOAD, make_seg(1'b0, 10, 10, 32'h0001_0000, 32'h0001_0000, 0,
                                             -32768, 32767));
      send_item(swcg_pkg::CMD_STEP, random_seg());
      send_item(swcg_pkg::CMD_LOAD, make_seg(1'b1, 32767, -32768, 32'h0001_0000,
                                             32'h0001_0000, 0, 0, 0));
      send_item(swcg_pkg::CMD_STEP, random_seg());
      // upper wall: y -100, 0, 100, 200 -> off screen, 1 row, 101 rows, clipped to 128
      send_item(swcg_pkg::CMD_LOAD, make_seg(1'b1, 0, 4, 32'hFFFC_0000, 32'h0004_0000,
                                             32'hFFCE_0000, -32768, 32767));
      repeat (5) send_item(swcg_pkg::CMD_STEP, random_seg());
      // lower wall, two hidden columns skipped, negative x: drawn twice then off
      send_item(swcg_pkg::CMD_LOAD, make_seg(1'b0, -10, 10, 32'h0000_0000, 32'h0004_0000,
                                             32'hFFD8_0000, -8, -4));
      repeat (5) send_item(swcg_pkg::CMD_STEP, random_seg());
      // extreme fields; visible range collapses to nothing
      send_item(swcg_pkg::CMD_LOAD, make_seg(1'b0, -32768, 32767, 32'h8000_0000,
                                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32767, -32768));
      send_item(swcg_pkg::CMD_STEP, random_seg());
      // empty visible range inside a real edge
      send_item(swcg_pkg::CMD_LOAD, make_seg(1'b1, 0, 10, 32'h0001_0000, 32'h0001_0000, 0,
                                             6, 6));
      send_item(swcg_pkg::CMD_STEP, random_seg());
      // widest edge, one visible column at the far end: huge skip product wraps
      send_item(swcg_pkg::CMD_LOAD, make_seg(1'b1, -32768, 32767, 32'h7FFF_FFFF,
                                             32'h8000_0000, 32'h8000_0000, 32766, 32767));
      repeat (2) send_item(swcg_pkg::CMD_STEP, random_seg());
   endtask

   // Register extremes, each followed by a handful of edges.
   task automatic test_register_extremes();
      write_regs(32'h8000_0000, 8'd0, 8'd0, 9'd0);
      repeat (5) run_wall_edge(1'b0);
      write_regs(32'h7FFF_FFFF, 8'd255, 8'd255, 9'd256);
      repeat (5) run_wall_edge(1'b0);
      write_regs($urandom, 8'($urandom), 8'h3F, 9'd256);
      repeat (5) run_wall_edge(1'b0);
      write_regs($urandom, 8'd255, 8'h0F, 9'd200);
      repeat (5) run_wall_edge(1'b0);
      write_regs(32'd0, 8'd0, 8'd255, 9'd128);
      repeat (5) run_wall_edge(1'b0);
   endtask

   // Bulk random traffic: mostly well-formed edges, some cut short, some noise;
   // occasional register changes, idle-free stretches and full drains.
   task automatic test_random_walls();
      int pick;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 7) == 0)
            no_idle = ~no_idle;
         if ($urandom_range(0, 24) == 0)
            write_regs($urandom, 8'($urandom), 8'((1 << $urandom_range(0, 8)) - 1),
                       9'($urandom_range(0, 256)));
         else if ($urandom_range(0, 14) == 0)
            drain();
         pick = $urandom_range(0, 19);
         if (pick < 14)
            run_wall_edge(1'b0);
         else if (pick < 17)
            run_wall_edge(1'b1);
         else
            run_noise();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_register_extremes();
      test_random_walls();
      drain();
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
